[rtl/ufs_pkg.sv]
// shared types and constants for the union-find engine
// no dependencies; imported by ufs_store, ufs_seq and union_find_by_size_unit
package ufs_pkg;

	localparam int NODE_W  = 10;
	localparam int COUNT_W = 11;

	// request codes carried on the mode port
	localparam logic OP_FIND  = 1'b0;
	localparam logic OP_MERGE = 1'b1;

	typedef logic [NODE_W-1:0]  node_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WALK_RD,
		ST_WALK,
		ST_COMP_RD,
		ST_COMP,
		ST_SZ_RA,
		ST_SZ_RB,
		ST_LINK,
		ST_SZ_ONE,
		ST_DONE
	} state_t;

	// memory request from the sequencer to the table store
	typedef struct packed {
		logic   p_we;
		node_t  p_waddr;
		node_t  p_wdata;
		node_t  p_raddr;
		logic   s_we;
		node_t  s_waddr;
		count_t s_wdata;
		node_t  s_raddr;
	} mem_req_t;

	typedef struct packed {
		node_t  root;
		count_t count;
		logic   joined;
	} result_t;

endpackage

[rtl/ufs_store.sv]
// parent table and set size memories with the clearing pass after reset
// depends on ufs_pkg
module ufs_store #(
	parameter int DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ufs_pkg::mem_req_t req,
	output ufs_pkg::node_t    p_rdata,
	output ufs_pkg::count_t   s_rdata,
	output logic              ready
);
	import ufs_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int SW = $clog2(DEPTH + 1);

	logic [AW-1:0] parent_mem [DEPTH];
	logic [SW-1:0] size_mem   [DEPTH];

	logic [AW-1:0] clr_idx_q;
	logic          clr_busy_q;
	logic [AW-1:0] p_rd_q;
	logic [SW-1:0] s_rd_q;

	// clearing pass: one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + AW'(1);
			if (clr_idx_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			parent_mem[clr_idx_q] <= clr_idx_q;
		end else if (req.p_we) begin
			parent_mem[req.p_waddr[AW-1:0]] <= req.p_wdata[AW-1:0];
		end
		p_rd_q <= parent_mem[req.p_raddr[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			size_mem[clr_idx_q] <= SW'(1);
		end else if (req.s_we) begin
			size_mem[req.s_waddr[AW-1:0]] <= req.s_wdata[SW-1:0];
		end
		s_rd_q <= size_mem[req.s_raddr[AW-1:0]];
	end

	assign p_rdata = NODE_W'(p_rd_q);
	assign s_rdata = COUNT_W'(s_rd_q);
	assign ready   = !clr_busy_q;

endmodule

[rtl/ufs_seq.sv]
// sequencer for root walks, path compression and the size-based link
// depends on ufs_pkg; drives ufs_store through a mem_req_t
module ufs_seq #(
	parameter int NODES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              mode,
	input  ufs_pkg::node_t    node_a,
	input  ufs_pkg::node_t    node_b,
	input  logic              store_ready,
	output ufs_pkg::mem_req_t req,
	input  ufs_pkg::node_t    p_rdata,
	input  ufs_pkg::count_t   s_rdata,
	output logic              res_valid,
	output ufs_pkg::result_t  res,
	input  logic              out_free
);
	import ufs_pkg::*;

	state_t  state_q, state_d;
	logic    merge_q, phase_b_q, moved_q, join_q;
	node_t   b_q, cur_q, start_q, top_q, ra_q, rb_q;
	count_t  sza_q;
	result_t res_q;

	logic    accept, a_ok, b_ok;
	node_t   cmp_x, cmp_y;
	logic    cmp_eq;
	logic    walk_end, to_phase_b;
	logic    link_swap;
	count_t  link_sum;
	node_t   link_root, link_child;
	state_t  after_walk;

	assign accept = in_valid && in_ready;
	assign a_ok   = 32'(node_a) < NODES;
	assign b_ok   = 32'(node_b) < NODES;

	// shared equality compare
	always_comb begin
		case (state_q)
			ST_WALK: begin
				cmp_x = p_rdata;
				cmp_y = cur_q;
			end
			ST_COMP: begin
				cmp_x = p_rdata;
				cmp_y = top_q;
			end
			default: begin
				cmp_x = ra_q;
				cmp_y = rb_q;
			end
		endcase
	end
	assign cmp_eq = cmp_x == cmp_y;

	assign walk_end   = (state_q == ST_WALK && cmp_eq && !moved_q)
		|| (state_q == ST_COMP && cmp_eq);
	assign to_phase_b = !phase_b_q && merge_q;
	assign after_walk = to_phase_b ? ST_WALK_RD : ST_SZ_RA;

	assign link_swap  = sza_q < s_rdata;
	assign link_sum   = sza_q + s_rdata;
	assign link_root  = link_swap ? rb_q : ra_q;
	assign link_child = link_swap ? ra_q : rb_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = a_ok ? ST_WALK_RD : ST_DONE;
				end
			end
			ST_WALK_RD: state_d = ST_WALK;
			ST_WALK: begin
				if (cmp_eq) begin
					state_d = moved_q ? ST_COMP_RD : after_walk;
				end
			end
			ST_COMP_RD: state_d = ST_COMP;
			ST_COMP: begin
				if (cmp_eq) begin
					state_d = after_walk;
				end
			end
			ST_SZ_RA: state_d = (merge_q && !cmp_eq) ? ST_SZ_RB : ST_SZ_ONE;
			ST_SZ_RB: state_d = ST_LINK;
			ST_LINK: state_d = ST_DONE;
			ST_SZ_ONE: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and memory requests
	always_comb begin
		req       = '0;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		req.p_raddr = cur_q;
		req.s_raddr = ra_q;
		case (state_q)
			ST_IDLE: in_ready = store_ready;
			ST_WALK: req.p_raddr = p_rdata;
			ST_COMP: begin
				req.p_raddr = p_rdata;
				req.p_we    = 1'b1;
				req.p_waddr = cur_q;
				req.p_wdata = top_q;
			end
			ST_SZ_RB: req.s_raddr = rb_q;
			ST_LINK: begin
				req.p_we    = 1'b1;
				req.p_waddr = link_child;
				req.p_wdata = link_root;
				req.s_we    = 1'b1;
				req.s_waddr = link_root;
				req.s_wdata = link_sum;
			end
			ST_DONE: res_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					merge_q   <= (mode == OP_MERGE) && b_ok;
					b_q       <= node_b;
					cur_q     <= node_a;
					start_q   <= node_a;
					phase_b_q <= 1'b0;
					moved_q   <= 1'b0;
					res_q     <= '{root: node_a, count: COUNT_W'(1), joined: 1'b0};
				end
			end
			ST_WALK: begin
				if (cmp_eq) begin
					top_q <= cur_q;
					if (phase_b_q) begin
						rb_q <= cur_q;
					end else begin
						ra_q <= cur_q;
					end
					// compression restarts from the walk's first node
					if (moved_q) begin
						cur_q <= start_q;
					end
				end else begin
					cur_q   <= p_rdata;
					moved_q <= 1'b1;
				end
			end
			ST_COMP: begin
				if (!cmp_eq) begin
					cur_q <= p_rdata;
				end
			end
			ST_SZ_RA: join_q <= merge_q && !cmp_eq;
			ST_SZ_RB: sza_q <= s_rdata;
			ST_LINK: res_q <= '{root: link_root, count: link_sum, joined: 1'b1};
			ST_SZ_ONE: res_q <= '{root: ra_q, count: s_rdata, joined: 1'b0};
			default: ;
		endcase
		// second walk starts from node_b
		if (walk_end && to_phase_b) begin
			cur_q     <= b_q;
			start_q   <= b_q;
			phase_b_q <= 1'b1;
			moved_q   <= 1'b0;
		end
	end

	assign res = res_q;

	// a finished result holds until the output register can take it
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && !out_free |=> state_q == ST_DONE)
		else $error("result dropped while output register full");

	// no parent write ever makes a node point at itself
	a_no_self_link: assert property (@(posedge clk) disable iff (!arst_n)
		req.p_we |-> req.p_waddr != req.p_wdata)
		else $error("parent write creates a self link");

	// sizes change only when two distinct sets are joined
	a_size_on_join: assert property (@(posedge clk) disable iff (!arst_n)
		req.s_we |-> join_q && merge_q && ra_q != rb_q)
		else $error("size written without a join");

	// no request is taken while the clearing pass runs
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!store_ready |-> !in_ready)
		else $error("request accepted during clearing pass");

	// an accepted request always leaves idle
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted request lost");

endmodule

[rtl/union_find_by_size_unit.sv]
// Disjoint-set engine with union by size and path compression. After reset
// a clearing pass over min(NODES,1024) entries sets every node to a singleton
// root of size one; no request is taken until it ends. A find request walks
// from node_a to its root one parent read per cycle, then rewrites every
// node on that path to point at the root, again one node per cycle, and
// reads the root's size. A merge does the same for node_b, then reads both
// sizes and, when the roots differ, links the smaller root under the larger.
// The single read port of the parent memory is why each walk reads one
// parent at a time. With union by size the depth stays at or below
// log2(NODES). A request whose node_a is at or above NODES returns node_a,
// size one, without a walk. The result sits in an output register so the
// next request can be taken while it waits.
// depends on ufs_pkg, ufs_store, ufs_seq
module union_find_by_size_unit #(
	parameter int NODES = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            mode,
	input  ufs_pkg::node_t  node_a,
	input  ufs_pkg::node_t  node_b,
	output logic            out_valid,
	input  logic            out_ready,
	output ufs_pkg::node_t  root,
	output ufs_pkg::count_t set_count,
	output logic            joined
);
	import ufs_pkg::*;

	// only indices that fit the node field are ever stored
	localparam int DEPTH = (NODES < (1 << NODE_W)) ? NODES : (1 << NODE_W);

	mem_req_t req;
	node_t    p_rdata;
	count_t   s_rdata;
	logic     store_ready;
	logic     res_valid;
	result_t  res;
	logic     out_free;
	logic     out_valid_q;
	result_t  out_q;

	ufs_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.p_rdata(p_rdata),
		.s_rdata(s_rdata),
		.ready  (store_ready)
	);

	ufs_seq #(
		.NODES(NODES)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.node_a     (node_a),
		.node_b     (node_b),
		.store_ready(store_ready),
		.req        (req),
		.p_rdata    (p_rdata),
		.s_rdata    (s_rdata),
		.res_valid  (res_valid),
		.res        (res),
		.out_free   (out_free)
	);

	// output register: empty, or its transaction completes this cycle
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign root      = out_q.root;
	assign set_count = out_q.count;
	assign joined    = out_q.joined;

endmodule

[test/tb.sv]
// self-checking testbench for union_find_by_size_unit: random find and merge traffic
// against a behavioral disjoint-set predictor kept inside the testbench
// depends on ufs_pkg and the rtl of union_find_by_size_unit
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ufs_pkg::*;

	localparam int NODES = 1024;
	localparam int RANDOM_ITEMS = 1150;
	localparam int TAIL_ITEMS = 100;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_AT = 200;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 64;

	typedef struct {
		logic  mode;
		node_t a;
		node_t b;
	} request_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    in_valid = 1'b0;
	logic    in_ready;
	logic    mode = OP_FIND;
	node_t   node_a = '0;
	node_t   node_b = '0;
	logic    out_valid;
	logic    out_ready = 1'b0;
	node_t   root;
	count_t  set_count;
	logic    joined;

	// stimulus waiting to be offered, and results still owed by the block
	request_t request_queue[$];
	result_t  owed_results[$];

	// testbench copy of the disjoint-set tables
	node_t  parent_copy[NODES];
	count_t size_copy[NODES];

	int     total_items = 0;
	int     n_in = 0;
	int     errors = 0;
	int     cycle_cnt = 0;
	logic   in_taken = 1'b0;
	int     in_gap = 0;
	int     out_gap = 0;
	int     hold_left = 0;
	bit     hold_done = 1'b0;
	int     last_base = 0;

	union_find_by_size_unit #(
		.NODES(NODES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.node_a(node_a),
		.node_b(node_b),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.root(root),
		.set_count(set_count),
		.joined(joined)
	);

	always #1 clk = ~clk;

	// walk to the root, then point every node on the path straight at it
	function automatic node_t find_root(node_t n);
		node_t top;
		node_t nxt;
		int    steps;
		top = n;
		steps = 0;
		while (parent_copy[top] != top && steps < NODES) begin
			top = node_t'(int'(parent_copy[top]) % NODES);
			steps++;
		end
		steps = 0;
		while (n != top && steps < NODES) begin
			nxt = node_t'(int'(parent_copy[n]) % NODES);
			parent_copy[n] = top;
			n = nxt;
			steps++;
		end
		return top;
	endfunction

	// apply one request to the table copy and return what the block must answer
	function automatic result_t apply_request(logic m, node_t a, node_t b);
		result_t r;
		node_t   ra;
		node_t   rb;
		node_t   t;
		r.root = a;
		r.count = count_t'(1);
		r.joined = 1'b0;
		if (int'(a) < NODES) begin
			ra = find_root(a);
			if (m == OP_MERGE && int'(b) < NODES) begin
				rb = find_root(b);
				if (ra != rb) begin
					// smaller set goes under the larger; on a tie node_a's root stays
					if (size_copy[ra] < size_copy[rb]) begin
						t = ra;
						ra = rb;
						rb = t;
					end
					parent_copy[rb] = ra;
					size_copy[ra] = size_copy[ra] + size_copy[rb];
					r.joined = 1'b1;
				end
			end
			r.root = ra;
			r.count = size_copy[ra];
		end
		return r;
	endfunction

	task automatic push_request(logic m, int a, int b);
		request_t q;
		q.mode = m;
		q.a = node_t'(a);
		q.b = node_t'(b);
		request_queue.insert(request_queue.size(), q);
		total_items++;
	endtask

	// pairwise doubling merges over 2**k nodes: builds a binomial tree of depth k,
	// rooted at base unless shuffle mixes in an occasional swapped operand order
	task automatic push_tree(int base, int k, bit shuffle);
		int s;
		int i;
		for (s = 1; s < (1 << k); s = s * 2) begin
			for (i = 0; i < (1 << k); i = i + 2 * s) begin
				if (shuffle && $urandom_range(0, 9) == 0)
					push_request(OP_MERGE, base + i + s, base + i);
				else
					push_request(OP_MERGE, base + i, base + i + s);
			end
		end
	endtask

	// monitor: predictor on every input transaction, checker on every output one
	always @(posedge clk) begin : monitor_proc
		result_t want;
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_cnt);
			$display("Some tests failed");
			$finish;
		end
		in_taken <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			owed_results.insert(owed_results.size(), apply_request(mode, node_a, node_b));
			n_in++;
		end
		if (arst_n && out_valid && out_ready) begin
			if (owed_results.size() == 0) begin
				$display("%0t: unexpected result root %0d set_count %0d joined %0d",
					$time, root, set_count, joined);
				errors++;
			end else begin
				want = owed_results.pop_front();
				if (root !== want.root) begin
					$display("%0t: root expected %0d, actual %0d", $time, want.root, root);
					errors++;
				end
				if (set_count !== want.count) begin
					$display("%0t: set_count expected %0d, actual %0d",
						$time, want.count, set_count);
					errors++;
				end
				if (joined !== want.joined) begin
					$display("%0t: joined expected %0d, actual %0d",
						$time, want.joined, joined);
					errors++;
				end
			end
		end
	end

	// driver: offers queued requests at the falling edge, with random idle bursts
	always @(negedge clk) begin : drive_proc
		request_t q;
		bit       tail;
		tail = (n_in >= total_items - TAIL_ITEMS);
		if (arst_n) begin
			if (in_valid && !in_taken) begin
				// hold the transaction until the block takes it
			end else if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap--;
			end else if (!tail && cycle_cnt[8] && $urandom_range(0, 5) == 0) begin
				in_valid <= 1'b0;
				in_gap = $urandom_range(0, 4);
			end else if (request_queue.size() != 0) begin
				q = request_queue.pop_front();
				in_valid <= 1'b1;
				mode <= q.mode;
				node_a <= q.a;
				node_b <= q.b;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off that backs the block up
	always @(negedge clk) begin : sink_proc
		bit tail;
		tail = (n_in >= total_items - TAIL_ITEMS);
		if (arst_n) begin
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (!hold_done && n_in >= HOLD_AT) begin
				out_ready <= 1'b0;
				hold_left = HOLD_CYCLES - 1;
				hold_done = 1'b1;
			end else if (out_gap > 0) begin
				out_ready <= 1'b0;
				out_gap--;
			end else if (!tail && (cycle_cnt[7] ^ cycle_cnt[9]) && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				out_gap = $urandom_range(0, 4);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : stim_proc
		int i;
		int sel;
		int k;
		int base;
		int n;
		int span;

		for (i = 0; i < NODES; i++) begin
			parent_copy[i] = node_t'(i);
			size_copy[i] = count_t'(1);
		end

		// directed part: extremes, self merge, ties, swaps, repeated merge
		push_request(OP_FIND, 0, 1023);
		push_request(OP_FIND, 1023, 0);
		push_request(OP_MERGE, 0, 0);
		push_request(OP_MERGE, 0, 1023);
		push_request(OP_MERGE, 1023, 0);
		push_request(OP_FIND, 1023, 1023);
		push_request(OP_MERGE, 5, 0);
		push_request(OP_MERGE, 682, 341);
		push_request(OP_MERGE, 682, 5);
		// a depth-four tree; its deepest leaf forces a full-depth walk and compression
		push_tree(512, 4, 1'b0);
		push_request(OP_FIND, 527, 0);
		push_request(OP_FIND, 527, 1023);

		// random part: mostly tree builds with finds into them, some noise
		while (total_items < RANDOM_ITEMS + 26) begin
			sel = $urandom_range(0, 9);
			if (sel < 4) begin
				k = $urandom_range(1, 6);
				base = $urandom_range(0, NODES - (1 << k));
				last_base = base;
				push_tree(base, k, 1'b1);
				push_request(OP_FIND, base + (1 << k) - 1, $urandom_range(0, 1023));
			end else if (sel < 7) begin
				n = $urandom_range(1, 8);
				span = (last_base > NODES - 64) ? NODES - last_base : 64;
				for (i = 0; i < n; i++)
					push_request($urandom_range(0, 1) ? OP_MERGE : OP_FIND,
						last_base + $urandom_range(0, span - 1),
						$urandom_range(0, 1) ? last_base + $urandom_range(0, span - 1)
							: $urandom_range(0, 1023));
			end else begin
				push_request($urandom_range(0, 1) ? OP_MERGE : OP_FIND,
					$urandom_range(0, 1023), $urandom_range(0, 1023));
			end
		end

		// single reset at the start; the block then runs its clearing pass
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// every request taken and every result back, then a quiet drain
		while (n_in < total_items || owed_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (errors == 0 && owed_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
